@@ rtl/presence_table_with_aging_defines.svh @@
// Assertion macros used by the presence table RTL.
`ifndef PRESENCE_TABLE_WITH_AGING_DEFINES_SVH
`define PRESENCE_TABLE_WITH_AGING_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define PTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication: cons must hold in the cycle after ante.
`define PTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pta_pkg.sv @@
// Types and constants of the presence table.
`default_nettype none

package pta_pkg;

  localparam int unsigned MAC_W     = 48;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TTL_RESET    = 32'd500;
  localparam logic [MAC_W-1:0]  TARGET_RESET = 48'hCBD0_7C59_0C0F;

  typedef enum logic [1:0] {
    STAT_UPDATED  = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_DROPPED  = 2'd2,
    STAT_SWEPT    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TTL    = 2'd0,
    CFG_TARGET = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic              named;
    logic [TIME_W-1:0] seen;
    logic [MAC_W-1:0]  addr;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/pta_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // read data holds when no read is issued
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/presence_table_with_aging.sv @@
// Presence table with aging: address-keyed device table, sweep and recount.
// A sighting searches the valid entries one per cycle through a single RAM read
// port, then updates the matching entry, or inserts the address when none matches
// and drops it when the table is full. A sweep removes stale entries by moving the
// last entry into the hole (no move when the removed entry is the last), then
// recounts the named entries and posts the result. A new request is accepted
// while a finished result still waits in the output register.
// The table RAM needs no clearing after reset.
`default_nettype none

module presence_table_with_aging
  import pta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [MAC_W-1:0]     cfg_data_i,
  // requests
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 action_i,
  input  wire logic [MAC_W-1:0]     device_mac_i,
  input  wire logic                 has_name_i,
  input  wire logic [TIME_W-1:0]    now_ms_i,
  // results
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [OUT_CNT_W-1:0]      entry_count_o,
  output logic [OUT_CNT_W-1:0]      named_count_o,
  output logic                      target_found_o
);

  `include "presence_table_with_aging_defines.svh"

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SRCH      = 8'b0000_0010,
    S_INS       = 8'b0000_0100,
    S_SWP_CHK   = 8'b0000_1000,
    S_SWP_MV    = 8'b0001_0000,
    S_CNT_START = 8'b0010_0000,
    S_CNT_CHK   = 8'b0100_0000,
    S_FIN       = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  named_q, named_d;
  logic              tgt_q, tgt_d;
  logic [TIME_W-1:0] ttl_q;
  logic [MAC_W-1:0]  target_q;
  status_e           stat_q, stat_d;
  logic              out_valid_q, out_valid_d;

  // request payload
  logic              act_q;
  logic [MAC_W-1:0]  mac_q;
  logic              has_name_q;
  logic [TIME_W-1:0] now_q;

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;

  logic              in_acc;
  logic              out_acc;
  logic              load_out;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [TIME_W-1:0] age;
  logic              stale;
  logic [MAC_W-1:0]  cmp_b;
  logic              addr_eq;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;

  assign idx_inc = idx_q + ONE_CNT;
  assign cnt_dec = cnt_q - ONE_CNT;

  // shared datapath: age check and one address comparator
  assign age     = now_q - ram_rdata.seen;
  assign stale   = age > ttl_q;
  assign cmp_b   = (state_q == S_CNT_CHK) ? target_q : mac_q;
  assign addr_eq = (ram_rdata.addr == cmp_b);

  pta_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    named_d   = named_q;
    tgt_d     = tgt_q;
    stat_d    = stat_q;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_inc[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d     = '0;
          ram_raddr = '0;
          if (cnt_q == '0) begin
            state_d = action_i ? S_CNT_START : S_INS;
          end else begin
            ram_re  = 1'b1;
            state_d = action_i ? S_SWP_CHK : S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (addr_eq) begin
          ram_we          = 1'b1;
          ram_wdata.named = ram_rdata.named | has_name_q;
          ram_wdata.seen  = now_q;
          stat_d          = STAT_UPDATED;
          state_d         = S_FIN;
        end else if (idx_inc == cnt_q) begin
          state_d = S_INS;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_inc;
        end
      end
      S_INS: begin
        ram_waddr = cnt_q[IDX_W-1:0];
        ram_wdata.named = has_name_q;
        ram_wdata.seen  = now_q;
        ram_wdata.addr  = mac_q;
        if (cnt_q < DEPTH_CNT) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + ONE_CNT;
          stat_d = STAT_INSERTED;
        end else begin
          stat_d = STAT_DROPPED;
        end
        state_d = S_FIN;
      end
      S_SWP_CHK: begin
        if (stale) begin
          cnt_d = cnt_dec;
          if (idx_q == cnt_dec) begin
            // the stale entry was the last one
            state_d = S_CNT_START;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cnt_dec[IDX_W-1:0];
            state_d   = S_SWP_MV;
          end
        end else if (idx_inc == cnt_q) begin
          state_d = S_CNT_START;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_inc;
        end
      end
      S_SWP_MV: begin
        // read data keeps the moved entry, so the slot is checked again from it
        ram_we  = 1'b1;
        state_d = S_SWP_CHK;
      end
      S_CNT_START: begin
        named_d   = '0;
        tgt_d     = 1'b0;
        idx_d     = '0;
        ram_raddr = '0;
        stat_d    = STAT_SWEPT;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          ram_re  = 1'b1;
          state_d = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        if (ram_rdata.named) begin
          named_d = named_q + ONE_CNT;
          if (addr_eq) begin
            tgt_d = 1'b1;
          end
        end
        if (idx_inc == cnt_q) begin
          state_d = S_FIN;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_inc;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      named_q     <= '0;
      tgt_q       <= 1'b0;
      stat_q      <= STAT_UPDATED;
      out_valid_q <= 1'b0;
      ttl_q       <= TTL_RESET;
      target_q    <= TARGET_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      named_q     <= named_d;
      tgt_q       <= tgt_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TTL:    ttl_q    <= cfg_data_i[TIME_W-1:0];
          CFG_TARGET: target_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q      <= action_i;
      mac_q      <= device_mac_i;
      has_name_q <= has_name_i;
      now_q      <= now_ms_i;
    end
    if (load_out) begin
      status_o       <= stat_q;
      entry_count_o  <= OUT_CNT_W'(cnt_q);
      named_count_o  <= OUT_CNT_W'(named_q);
      target_found_o <= tgt_q;
    end
  end

  `PTA_ASSERT(a_cnt_in_range, cnt_q <= DEPTH_CNT, "entry count above table depth")
  `PTA_ASSERT(a_idx_below_cnt,
    (state_q != S_SRCH && state_q != S_SWP_CHK && state_q != S_CNT_CHK) || (idx_q < cnt_q),
    "entry index not below entry count")
  `PTA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "request accepted but not busy")
  `PTA_ASSERT_NEXT(a_sweep_path, in_acc && action_i,
    state_q == S_SWP_CHK || state_q == S_CNT_START, "sweep request took sighting path")
  `PTA_ASSERT(a_sighting_status,
    !(load_out && !act_q) || (stat_q != STAT_SWEPT), "sighting reported as sweep")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the presence table: directed table, random phases, predictor.
`timescale 1ns / 100ps

module tb;
  import pta_pkg::*;

  localparam int TABLE_SLOTS = 24;

  localparam logic ACT_SIGHT = 1'b0;
  localparam logic ACT_SWEEP = 1'b1;

  // unused register indexes; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    status_e                status;
    logic [OUT_CNT_W-1:0]   entry_count;
    logic [OUT_CNT_W-1:0]   named_count;
    logic                   target_found;
  } report_t;

  typedef struct packed {
    logic              act;
    logic [MAC_W-1:0]  mac;
    logic              nm;
    logic [TIME_W-1:0] now;
    logic              known;
    report_t           want;
  } step_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [MAC_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 action_i;
  logic [MAC_W-1:0]     device_mac_i;
  logic                 has_name_i;
  logic [TIME_W-1:0]    now_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic [OUT_CNT_W-1:0] entry_count_o;
  logic [OUT_CNT_W-1:0] named_count_o;
  logic                 target_found_o;

  // predictor state
  logic [MAC_W-1:0]  tbl_addr [TABLE_SLOTS];
  logic [TIME_W-1:0] tbl_seen [TABLE_SLOTS];
  logic              tbl_named [TABLE_SLOTS];
  int                tbl_count;
  int                tbl_named_total;
  logic              tbl_target_hit;
  logic [TIME_W-1:0] ttl_reg;
  logic [MAC_W-1:0]  target_reg;

  report_t reports_due[$];
  int      reports_checked = 0;
  int      fail_cnt = 0;
  bit      calm = 1'b0;

  presence_table_with_aging #(
    .TABLE_DEPTH(TABLE_SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .device_mac_i  (device_mac_i),
    .has_name_i    (has_name_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .named_count_o (named_count_o),
    .target_found_o(target_found_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [MAC_W-1:0] rnd48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  // Sighting searches, updates or appends; sweep ages out entries by moving
  // the last one into the hole and rechecking that slot, then recounts.
  function automatic report_t table_step(input step_t s);
    report_t           r;
    int                i;
    int                hit;
    logic [TIME_W-1:0] age;
    hit = -1;
    if (s.act == ACT_SIGHT) begin
      for (i = 0; i < tbl_count; i++)
        if (hit < 0 && tbl_addr[i] == s.mac) hit = i;
      if (hit >= 0) begin
        tbl_seen[hit] = s.now;
        tbl_named[hit] = tbl_named[hit] | s.nm;
        r.status = STAT_UPDATED;
      end else if (tbl_count < TABLE_SLOTS) begin
        tbl_addr[tbl_count] = s.mac;
        tbl_seen[tbl_count] = s.now;
        tbl_named[tbl_count] = s.nm;
        tbl_count++;
        r.status = STAT_INSERTED;
      end else begin
        r.status = STAT_DROPPED;
      end
    end else begin
      i = 0;
      while (i < tbl_count) begin
        age = s.now - tbl_seen[i];
        if (age > ttl_reg) begin
          tbl_count--;
          tbl_addr[i] = tbl_addr[tbl_count];
          tbl_seen[i] = tbl_seen[tbl_count];
          tbl_named[i] = tbl_named[tbl_count];
        end else begin
          i++;
        end
      end
      tbl_named_total = 0;
      tbl_target_hit = 1'b0;
      for (i = 0; i < tbl_count; i++)
        if (tbl_named[i]) begin
          tbl_named_total++;
          if (tbl_addr[i] == target_reg) tbl_target_hit = 1'b1;
        end
      r.status = STAT_SWEPT;
    end
    r.entry_count = OUT_CNT_W'(tbl_count);
    r.named_count = OUT_CNT_W'(tbl_named_total);
    r.target_found = tbl_target_hit;
    return r;
  endfunction

  function automatic step_t row_pred(input logic act, input logic [MAC_W-1:0] mac,
                                     input logic nm, input logic [TIME_W-1:0] now);
    step_t s;
    s = '0;
    s.act = act;
    s.mac = mac;
    s.nm = nm;
    s.now = now;
    return s;
  endfunction

  function automatic step_t row_known(input logic act, input logic [MAC_W-1:0] mac,
                                      input logic nm, input logic [TIME_W-1:0] now,
                                      input status_e st, input int ec, input int nc,
                                      input logic tf);
    step_t s;
    s = row_pred(act, mac, nm, now);
    s.known = 1'b1;
    s.want.status = st;
    s.want.entry_count = OUT_CNT_W'(ec);
    s.want.named_count = OUT_CNT_W'(nc);
    s.want.target_found = tf;
    return s;
  endfunction

  function automatic void check_field(input string what, input logic [OUT_CNT_W-1:0] want,
                                      input logic [OUT_CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic send_req(input step_t s);
    report_t r;
    action_i <= s.act;
    device_mac_i <= s.mac;
    has_name_i <= s.nm;
    now_ms_i <= s.now;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = table_step(s);
    reports_due.push_back(s.known ? s.want : r);
  endtask

  task automatic idle_maybe();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_TTL:    ttl_reg = d[TIME_W-1:0];
      CFG_TARGET: target_reg = d;
      default:    ;
    endcase
  endtask

  task automatic run_phase(input logic [MAC_W-1:0] ttl_data, input logic [MAC_W-1:0] tgt,
                           input int n_pool, input logic [TIME_W-1:0] step_max,
                           input logic [TIME_W-1:0] start_ms, input int n_items,
                           input int pause_at, input bit spare);
    logic [MAC_W-1:0]  mac_pool [64];
    logic [TIME_W-1:0] clock_ms;
    step_t             s;
    int                k;
    drain();
    write_reg(CFG_TTL, ttl_data);
    write_reg(CFG_TARGET, tgt);
    if (spare) begin
      write_reg(CFG_SPARE_LO, rnd48());
      write_reg(CFG_SPARE_HI, '1);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    mac_pool[0] = tgt;
    mac_pool[1] = '0;
    mac_pool[2] = '1;
    for (k = 3; k < n_pool; k++) mac_pool[k] = rnd48();
    clock_ms = start_ms;
    for (k = 0; k < n_items; k++) begin
      if (k == pause_at) drain();
      else idle_maybe();
      // mostly forward time, now and then a step back
      if ($urandom_range(0, 29) == 0) clock_ms -= $urandom_range(0, step_max);
      else clock_ms += $urandom_range(0, step_max);
      s = '0;
      s.now = clock_ms;
      s.nm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) begin
        s.act = ACT_SWEEP;
        s.mac = rnd48();
      end else begin
        s.act = ACT_SIGHT;
        s.mac = ($urandom_range(0, 15) == 0) ? rnd48() : mac_pool[$urandom_range(0, n_pool - 1)];
      end
      send_req(s);
    end
  endtask

  initial begin : stimulus
    step_t             dir_tab[$];
    int                k;
    logic [TIME_W-1:0] ttl_r;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_TTL;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i = ACT_SIGHT;
    device_mac_i = '0;
    has_name_i = 1'b0;
    now_ms_i = '0;
    ttl_reg = TTL_RESET;
    target_reg = TARGET_RESET;
    tbl_count = 0;
    tbl_named_total = 0;
    tbl_target_hit = 1'b0;

    dir_tab = '{
      row_known(ACT_SWEEP, '0, 1'b0, 32'd0, STAT_SWEPT, 0, 0, 1'b0),
      row_known(ACT_SIGHT, '0, 1'b0, 32'd0, STAT_INSERTED, 1, 0, 1'b0),
      row_known(ACT_SIGHT, '1, 1'b1, 32'hFFFF_FFFF, STAT_INSERTED, 2, 0, 1'b0),
      row_known(ACT_SIGHT, TARGET_RESET, 1'b0, 32'd100, STAT_INSERTED, 3, 0, 1'b0),
      row_known(ACT_SIGHT, TARGET_RESET, 1'b1, 32'd200, STAT_UPDATED, 3, 0, 1'b0),
      // sweep ignores address and name; oldest entry has a wrapped age of 201
      row_known(ACT_SWEEP, '1, 1'b1, 32'd200, STAT_SWEPT, 3, 2, 1'b1),
      row_known(ACT_SIGHT, '0, 1'b0, 32'd700, STAT_UPDATED, 3, 2, 1'b1),
      // remove, move last into the hole, and remove that one too (age 501)
      row_known(ACT_SWEEP, '0, 1'b0, 32'd701, STAT_SWEPT, 1, 0, 1'b0),
      row_known(ACT_SIGHT, 48'h8000_0000_0001, 1'b1, 32'd1000, STAT_INSERTED, 2, 0, 1'b0),
      // age equal to ttl survives
      row_known(ACT_SWEEP, '0, 1'b0, 32'd1500, STAT_SWEPT, 1, 1, 1'b0),
      row_pred(ACT_SIGHT, 48'h5555_5555_5555, 1'b0, 32'd2000),
      row_pred(ACT_SIGHT, 48'hAAAA_AAAA_AAAA, 1'b1, 32'd2000),
      // timestamps in the future look very old
      row_known(ACT_SWEEP, '0, 1'b0, 32'd1999, STAT_SWEPT, 0, 0, 1'b0),
      row_pred(ACT_SIGHT, TARGET_RESET, 1'b1, 32'hFFFF_FF00),
      row_pred(ACT_SIGHT, TARGET_RESET, 1'b0, 32'h0000_0010),
      row_known(ACT_SWEEP, '0, 1'b0, 32'h0000_0100, STAT_SWEPT, 1, 1, 1'b1),
      row_pred(ACT_SIGHT, '0, 1'b1, 32'd5)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_tab.size(); k++) begin
      idle_maybe();
      send_req(dir_tab[k]);
    end

    run_phase(48'hFFFF_0000_0040, rnd48(), 30, 32'd20, $urandom, 120, -1, 1'b1);
    run_phase('0, '0, 8, 32'd2, $urandom, 100, -1, 1'b0);
    // nothing ever ages out here, so the table fills and drops requests
    run_phase('1, '1, 40, 32'hFFFF_FFFF, $urandom, 140, 20, 1'b0);
    ttl_r = $urandom_range(100, 5000);
    run_phase({16'h0, ttl_r}, rnd48(), 30, ttl_r / 8, 32'hFFFF_F000, 160, -1, 1'b0);
    calm = 1'b1;
    run_phase({16'h0, TTL_RESET}, TARGET_RESET, 26, 32'd60, $urandom, 160, -1, 1'b0);

    drain();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_side
    report_t want;
    int      burst;
    int      hold;
    bit      held;
    burst = 0;
    hold = 0;
    held = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (reports_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got status %0d", $time, status_o);
          fail_cnt++;
        end else begin
          want = reports_due.pop_front();
          check_field("status", OUT_CNT_W'(want.status), OUT_CNT_W'(status_o));
          check_field("entry_count", want.entry_count, entry_count_o);
          check_field("named_count", want.named_count, named_count_o);
          check_field("target_found", OUT_CNT_W'(want.target_found), OUT_CNT_W'(target_found_o));
        end
        reports_checked++;
      end
      // one long hold-off so the block backs up into its request side
      if (!held && reports_checked >= 300) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

endmodule
